// ===== hdl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, types and helpers for the block bitmap allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Geometry of the block bitmap (MAP_WORD_BITS must be a power of two)
    localparam int TOTAL_BLOCK_COUNT = 4096;
    localparam int FIRST_DATA_BLOCK  = 64;
    localparam int MAP_WORD_BITS     = 32;

    localparam int MAP_WORDS = (TOTAL_BLOCK_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int BLK_W     = WORD_AW + BIT_W;

    // Field widths of the transactions
    localparam int IDX_W    = 12;
    localparam int STATUS_W = 2;

    // Scan window in words
    localparam bit DATA_EMPTY = (FIRST_DATA_BLOCK >= TOTAL_BLOCK_COUNT);
    localparam int FIRST_WORD = FIRST_DATA_BLOCK / MAP_WORD_BITS;
    localparam int LAST_WORD  = (TOTAL_BLOCK_COUNT - 1) / MAP_WORD_BITS;
    localparam int FIRST_BIT  = FIRST_DATA_BLOCK % MAP_WORD_BITS;
    localparam int LAST_BITS  = TOTAL_BLOCK_COUNT - LAST_WORD * MAP_WORD_BITS;

    // Actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RSVD  = 2'd3;

    typedef struct packed {
        logic             action;
        logic [IDX_W-1:0] block_index;
    } bba_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    granted_index;
    } bba_resp_t;

    // Word with the low n bits set
    function automatic logic [MAP_WORD_BITS-1:0] low_mask(input int n);
        logic [MAP_WORD_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < MAP_WORD_BITS; i++) begin
            if (i < n) m[i] = 1'b1;
        end
        return m;
    endfunction

    // Blocks outside the data range in the edge words read as used
    localparam logic [MAP_WORD_BITS-1:0] FIRST_MASK = low_mask(FIRST_BIT);
    localparam logic [MAP_WORD_BITS-1:0] LAST_MASK  = ~low_mask(LAST_BITS);

endpackage

// ===== hdl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) rdata <= mem[raddr];
    end

endmodule

// ===== hdl/block_bitmap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// block_bitmap_allocator_unit
// First-fit allocator over a used/free bitmap of disk blocks held in RAM.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------
//  s_       | in  | s_valid / s_ready  | s_data  : action, block_index
//  m_       | out | m_valid / m_ready  | m_data  : status, granted_index
//
//  Allocate: the bitmap is read one word per cycle from the first data word;
//  the lowest clear bit of the first word that has one is granted, else FULL.
//  Free: read, modify/write back, result; out of range: straight to the result.
//  Reset clears per-word valid flags, so every block is free right away.
//  One transaction is in flight at a time; a new request is taken as soon as
//  the result sits in the output register, even while m_ready is low.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_unit
    import bba_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  bba_req_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output bba_resp_t m_data
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_FREE_RD = 3'd2;
    localparam logic [2:0] ST_FREE_WR = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [WORD_AW-1:0]     scan_addr_reg, scan_addr_next;
    logic [WORD_AW-1:0]     eval_addr_reg, eval_addr_next;
    logic                   issue_reg, issue_next;
    logic                   eval_valid_reg, eval_valid_next;
    logic [BLK_W-1:0]       blk_reg, blk_next;
    bba_resp_t              res_reg, res_next;
    logic                   m_valid_reg, m_valid_next;
    bba_resp_t              m_data_reg, m_data_next;
    logic [MAP_WORDS-1:0]   valid_reg, valid_next;

    logic                     ram_we, ram_re;
    logic [WORD_AW-1:0]       ram_waddr, ram_raddr;
    logic [MAP_WORD_BITS-1:0] ram_wdata, ram_rdata;

    logic [MAP_WORD_BITS-1:0] scan_word, scan_masked, free_word;
    logic                     zero_found;
    logic [BIT_W-1:0]         zero_bit;
    logic                     in_range;

    bba_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Range check of a free request
    assign in_range = (32'(s_data.block_index) >= FIRST_DATA_BLOCK) &&
                      (32'(s_data.block_index) < TOTAL_BLOCK_COUNT);

    // Word under evaluation, never-written words read as all free
    always_comb begin
        scan_word   = valid_reg[eval_addr_reg] ? ram_rdata : '0;
        scan_masked = scan_word
                    | ((32'(eval_addr_reg) == FIRST_WORD) ? FIRST_MASK : '0)
                    | ((32'(eval_addr_reg) == LAST_WORD)  ? LAST_MASK  : '0);
        free_word   = valid_reg[blk_reg[BLK_W-1:BIT_W]] ? ram_rdata : '0;
    end

    // Lowest clear bit of the masked word
    always_comb begin
        zero_found = ~&scan_masked;
        zero_bit   = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
            if (!scan_masked[i]) zero_bit = BIT_W'(i);
        end
    end

    // Control and datapath next state
    always_comb begin
        state_next      = state_reg;
        scan_addr_next  = scan_addr_reg;
        eval_addr_next  = eval_addr_reg;
        issue_next      = issue_reg;
        eval_valid_next = 1'b0;
        blk_next        = blk_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        valid_next      = valid_reg;
        ram_we          = 1'b0;
        ram_waddr       = eval_addr_reg;
        ram_wdata       = scan_word;
        ram_re          = 1'b0;
        ram_raddr       = scan_addr_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_next.granted_index = '0;
                    if (s_data.action == ACT_ALLOC) begin
                        if (DATA_EMPTY) begin
                            res_next.status = STATUS_FULL;
                            state_next      = ST_DONE;
                        end else begin
                            scan_addr_next = WORD_AW'(FIRST_WORD);
                            issue_next     = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end else if (!in_range) begin
                        res_next.status = STATUS_RANGE;
                        state_next      = ST_DONE;
                    end else begin
                        blk_next   = BLK_W'(s_data.block_index);
                        state_next = ST_FREE_RD;
                    end
                end
            end
            ST_SCAN: begin
                // Read pipeline: one word issued per cycle
                if (issue_reg) begin
                    ram_re          = 1'b1;
                    eval_valid_next = 1'b1;
                    eval_addr_next  = scan_addr_reg;
                    scan_addr_next  = scan_addr_reg + 1'b1;
                    if (32'(scan_addr_reg) == LAST_WORD) issue_next = 1'b0;
                end
                // Evaluate the word read last cycle
                if (eval_valid_reg) begin
                    if (zero_found) begin
                        ram_we                 = 1'b1;
                        ram_waddr              = eval_addr_reg;
                        ram_wdata              = scan_word
                                               | (MAP_WORD_BITS'(1) << zero_bit);
                        valid_next[eval_addr_reg] = 1'b1;
                        res_next.status        = STATUS_OK;
                        res_next.granted_index = IDX_W'({eval_addr_reg, zero_bit});
                        issue_next             = 1'b0;
                        eval_valid_next        = 1'b0;
                        state_next             = ST_DONE;
                    end else if (32'(eval_addr_reg) == LAST_WORD) begin
                        res_next.status = STATUS_FULL;
                        issue_next      = 1'b0;
                        eval_valid_next = 1'b0;
                        state_next      = ST_DONE;
                    end
                end
            end
            ST_FREE_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = blk_reg[BLK_W-1:BIT_W];
                state_next = ST_FREE_WR;
            end
            ST_FREE_WR: begin
                ram_we    = 1'b1;
                ram_waddr = blk_reg[BLK_W-1:BIT_W];
                ram_wdata = free_word & ~(MAP_WORD_BITS'(1) << blk_reg[BIT_W-1:0]);
                valid_next[blk_reg[BLK_W-1:BIT_W]] = 1'b1;
                res_next.status = STATUS_OK;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                // Hand the result to the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            issue_reg      <= 1'b0;
            eval_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            valid_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            eval_valid_reg <= eval_valid_next;
            m_valid_reg    <= m_valid_next;
            valid_reg      <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        scan_addr_reg <= scan_addr_next;
        eval_addr_reg <= eval_addr_next;
        blk_reg       <= blk_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    // Checks
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.status != STATUS_RSVD))
        else $error("reserved status code on output");

    a_grant_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status == STATUS_OK && m_data_reg.granted_index != '0)
        |-> (32'(m_data_reg.granted_index) >= FIRST_DATA_BLOCK))
        else $error("granted block below first data block");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_SCAN || state_reg == ST_FREE_WR))
        else $error("bitmap write outside scan or free");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("request accepted without starting work");

endmodule
